@@ rtl/core/backslash_escape_decoder_defines.svh @@
// Assertion macros for the backslash escape decoder.
`ifndef BACKSLASH_ESCAPE_DECODER_DEFINES_SVH
`define BACKSLASH_ESCAPE_DECODER_DEFINES_SVH

`ifndef SYNTH

`define BED_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("backslash_escape_decoder: same-cycle check failed");

`define BED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("backslash_escape_decoder: next-cycle check failed");

`else

`define BED_ASSERT_SAME(label, clk, rst, ante, cons)

`define BED_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/bed_pkg.sv @@
package bed_pkg;

   localparam int MaxRes = 3;
   localparam int CountW = $clog2(MaxRes + 1);

   localparam logic RegInterpret = 1'b0;
   localparam logic RegEscEnable = 1'b1;

   localparam logic [2:0] ModeNormal = 3'd0;
   localparam logic [2:0] ModeEsc    = 3'd1;
   localparam logic [2:0] ModeHex0   = 3'd2;
   localparam logic [2:0] ModeHex1   = 3'd3;
   localparam logic [2:0] ModeOct0   = 3'd4;
   localparam logic [2:0] ModeOctN   = 3'd5;

   localparam logic [7:0] ChBackslash = 8'h5c;
   localparam logic [7:0] ChLowA      = 8'h61;
   localparam logic [7:0] ChLowB      = 8'h62;
   localparam logic [7:0] ChLowC      = 8'h63;
   localparam logic [7:0] ChLowE      = 8'h65;
   localparam logic [7:0] ChLowF      = 8'h66;
   localparam logic [7:0] ChLowN      = 8'h6e;
   localparam logic [7:0] ChLowR      = 8'h72;
   localparam logic [7:0] ChLowT      = 8'h74;
   localparam logic [7:0] ChLowV      = 8'h76;
   localparam logic [7:0] ChLowX      = 8'h78;
   localparam logic [7:0] ChZero      = 8'h30;
   localparam logic [7:0] ChSeven     = 8'h37;
   localparam logic [7:0] ChNine      = 8'h39;
   localparam logic [7:0] ChUpA       = 8'h41;
   localparam logic [7:0] ChUpF       = 8'h46;

   localparam logic [7:0] CodeBel = 8'h07;
   localparam logic [7:0] CodeBs  = 8'h08;
   localparam logic [7:0] CodeHt  = 8'h09;
   localparam logic [7:0] CodeLf  = 8'h0a;
   localparam logic [7:0] CodeVt  = 8'h0b;
   localparam logic [7:0] CodeFf  = 8'h0c;
   localparam logic [7:0] CodeCr  = 8'h0d;
   localparam logic [7:0] CodeEsc = 8'h1b;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       stop;
   } res_entry_type;

   typedef struct packed {
      res_entry_type [MaxRes-1:0] slot;
      logic [CountW-1:0]          count;
   } res_list_type;

   typedef struct packed {
      logic halted;
   } dec_status_type;

   typedef struct packed {
      logic free;
      logic busy;
   } buf_status_type;

   function automatic res_list_type push(input res_list_type l, input logic [7:0] d,
                                         input logic v, input logic s);
      res_list_type r;
      r = l;
      if (l.count < CountW'(MaxRes)) begin
         r.slot[l.count].data  = d;
         r.slot[l.count].valid = v;
         r.slot[l.count].stop  = s;
         r.count = l.count + CountW'(1);
      end
      return r;
   endfunction

   // Returns {is_hex_digit, digit_value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= ChZero && b <= ChNine) begin
         r = {1'b1, 4'(b - ChZero)};
      end else if (b >= ChLowA && b <= ChLowF) begin
         r = {1'b1, 4'(b - ChLowA + 8'd10)};
      end else if (b >= ChUpA && b <= ChUpF) begin
         r = {1'b1, 4'(b - ChUpA + 8'd10)};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/bed_decode.sv @@
module bed_decode import bed_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           interpret,
   input  logic           esc_enabled,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output res_list_type   list,
   output dec_status_type status
);

   logic [2:0] mode_ff, mode_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [8:0] acc_ff, acc_in;
   logic       halted_ff, halted_in;

   logic [4:0] hex;
   logic       is_oct;
   logic [2:0] oct_val;
   logic [8:0] val;
   logic [1:0] cnt_next;
   logic       do_plain;
   res_list_type l;

   always_comb begin
      hex      = hex_digit(in_byte);
      is_oct   = (in_byte >= ChZero) && (in_byte <= ChSeven);
      oct_val  = in_byte[2:0];
      val      = '0;
      cnt_next = cnt_ff + 2'd1;
      do_plain = 1'b0;
      l        = '0;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      halted_in = halted_ff;
      if (halted_ff) begin
         l = '0;
      end else if (!interpret) begin
         mode_in = ModeNormal;
         cnt_in  = '0;
         acc_in  = '0;
         l = push(l, in_byte, 1'b1, 1'b0);
      end else begin
         unique case (mode_ff)
            ModeEsc: begin
               mode_in = ModeNormal;
               unique case (in_byte)
                  ChBackslash: l = push(l, ChBackslash, 1'b1, 1'b0);
                  ChLowA:      l = push(l, CodeBel, 1'b1, 1'b0);
                  ChLowB:      l = push(l, CodeBs, 1'b1, 1'b0);
                  ChLowF:      l = push(l, CodeFf, 1'b1, 1'b0);
                  ChLowN:      l = push(l, CodeLf, 1'b1, 1'b0);
                  ChLowR:      l = push(l, CodeCr, 1'b1, 1'b0);
                  ChLowT:      l = push(l, CodeHt, 1'b1, 1'b0);
                  ChLowV:      l = push(l, CodeVt, 1'b1, 1'b0);
                  ChLowC: begin
                     halted_in = 1'b1;
                     l = push(l, 8'h00, 1'b0, 1'b1);
                  end
                  ChLowX:      mode_in = ModeHex0;
                  ChZero:      mode_in = ModeOct0;
                  ChLowE: begin
                     if (esc_enabled) begin
                        l = push(l, CodeEsc, 1'b1, 1'b0);
                     end else begin
                        l = push(l, ChBackslash, 1'b1, 1'b0);
                        do_plain = 1'b1;
                     end
                  end
                  default: begin
                     l = push(l, ChBackslash, 1'b1, 1'b0);
                     do_plain = 1'b1;
                  end
               endcase
            end
            ModeHex0: begin
               if (hex[4]) begin
                  acc_in  = {5'd0, hex[3:0]};
                  mode_in = ModeHex1;
               end else begin
                  l = push(l, ChBackslash, 1'b1, 1'b0);
                  l = push(l, ChLowX, 1'b1, 1'b0);
                  mode_in  = ModeNormal;
                  do_plain = 1'b1;
               end
            end
            ModeHex1: begin
               mode_in = ModeNormal;
               val = hex[4] ? {acc_ff[4:0], hex[3:0]} : acc_ff;
               if (val != '0) begin
                  l = push(l, val[7:0], 1'b1, 1'b0);
               end
               acc_in   = '0;
               cnt_in   = '0;
               do_plain = !hex[4];
            end
            ModeOct0: begin
               if (is_oct) begin
                  acc_in  = {6'd0, oct_val};
                  cnt_in  = 2'd1;
                  mode_in = ModeOctN;
               end else begin
                  l = push(l, ChBackslash, 1'b1, 1'b0);
                  l = push(l, ChZero, 1'b1, 1'b0);
                  mode_in  = ModeNormal;
                  do_plain = 1'b1;
               end
            end
            ModeOctN: begin
               if (is_oct && cnt_next != 2'd3 && cnt_next != 2'd0) begin
                  acc_in = {acc_ff[5:0], oct_val};
                  cnt_in = cnt_next;
               end else begin
                  mode_in = ModeNormal;
                  val = is_oct ? {acc_ff[5:0], oct_val} : acc_ff;
                  if (val != '0) begin
                     l = push(l, val[7:0], 1'b1, 1'b0);
                  end
                  acc_in   = '0;
                  cnt_in   = '0;
                  do_plain = !is_oct;
               end
            end
            default: begin
               mode_in  = ModeNormal;
               do_plain = 1'b1;
            end
         endcase

         if (do_plain) begin
            if (in_byte == ChBackslash) begin
               mode_in = ModeEsc;
            end else begin
               l = push(l, in_byte, 1'b1, 1'b0);
            end
         end

         if (in_last && !halted_in) begin
            unique case (mode_in)
               ModeEsc: l = push(l, ChBackslash, 1'b1, 1'b0);
               ModeHex0: begin
                  l = push(l, ChBackslash, 1'b1, 1'b0);
                  l = push(l, ChLowX, 1'b1, 1'b0);
               end
               ModeOct0: begin
                  l = push(l, ChBackslash, 1'b1, 1'b0);
                  l = push(l, ChZero, 1'b1, 1'b0);
               end
               ModeHex1, ModeOctN: begin
                  if (acc_in != '0) begin
                     l = push(l, acc_in[7:0], 1'b1, 1'b0);
                  end
               end
               default: begin
                  l = l;
               end
            endcase
            mode_in = ModeNormal;
            acc_in  = '0;
            cnt_in  = '0;
         end
      end

      if (!halted_ff && in_last && l.count == '0) begin
         l = push(l, 8'h00, 1'b0, 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeNormal;
         cnt_ff    <= '0;
         acc_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         cnt_ff    <= cnt_in;
         acc_ff    <= acc_in;
         halted_ff <= halted_in;
      end
   end

   assign list          = l;
   assign status.halted = halted_ff;

endmodule

@@ rtl/core/bed_outbuf.sv @@
module bed_outbuf import bed_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  res_list_type   list,
   input  logic           in_last,
   input  logic           rsp_ready,
   output buf_status_type status,
   output logic           rsp_valid,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_byte_valid,
   output logic           rsp_run_last,
   output logic           rsp_string_end,
   output logic           rsp_stopped
);

   res_entry_type [MaxRes-1:0] slot_ff, slot_in;
   logic [CountW-1:0]          count_ff, count_in;
   logic [CountW-1:0]          rd_ff, rd_in;
   logic                       last_ff, last_in;
   logic                       pop;
   res_entry_type              head;

   assign pop  = rsp_valid && rsp_ready;
   assign head = slot_ff[rd_ff];

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      last_in  = last_ff;
      if (load) begin
         slot_in  = list.slot;
         count_in = list.count;
         rd_in    = '0;
         last_in  = in_last;
      end else if (pop) begin
         count_in = count_ff - CountW'(1);
         rd_in    = rd_ff + CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign status.free    = (count_ff == '0) || ((count_ff == CountW'(1)) && rsp_ready);
   assign status.busy    = (count_ff != '0);
   assign rsp_valid      = (count_ff != '0);
   assign rsp_out_byte   = head.data;
   assign rsp_byte_valid = head.valid;
   assign rsp_stopped    = head.stop;
   assign rsp_run_last   = (count_ff == CountW'(1));
   assign rsp_string_end = (count_ff == CountW'(1)) && last_ff;

endmodule

@@ rtl/core/backslash_escape_decoder.sv @@
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_in_byte, req_in_last
// rsp       out        rsp_valid/rsp_ready   rsp_out_byte, rsp_byte_valid, rsp_run_last,
//                                            rsp_string_end, rsp_stopped
// csr       in         csr_wr_en             csr_index, csr_wdata
//
// A byte is decoded straight out of the input register and loaded into the result buffer
// once that buffer is free; its results are offered from the result buffer.
// One byte is taken per cycle while rsp_ready is high and each byte gives at most one result;
// a byte that gives more than one result holds the single result port until each is taken.
// Synchronous reset clears the decode state, the stop flag and both buffers.
// While rsp is stalled or still busy with earlier results, an input register that holds a
// byte keeps it and req_ready is low in that same cycle.
`include "backslash_escape_decoder_defines.svh"

module backslash_escape_decoder import bed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end,
   output logic       rsp_stopped,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic       csr_wdata
);

   logic           interpret_ff, esc_en_ff;
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           advance;
   logic           take;
   res_list_type   list;
   dec_status_type dec_status;
   buf_status_type buf_status;

   assign advance     = in_valid_ff && buf_status.free;
   assign req_ready   = !in_valid_ff || advance;
   assign take        = req_valid && req_ready;
   assign in_valid_in = take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         interpret_ff <= 1'b0;
         esc_en_ff    <= 1'b1;
         in_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en && csr_index == RegInterpret) begin
            interpret_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == RegEscEnable) begin
            esc_en_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   bed_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .interpret   (interpret_ff),
      .esc_enabled (esc_en_ff),
      .in_byte     (in_byte_ff),
      .in_last     (in_last_ff),
      .list        (list),
      .status      (dec_status)
   );

   bed_outbuf u_outbuf (
      .clock          (clock),
      .reset          (reset),
      .load           (advance),
      .list           (list),
      .in_last        (in_last_ff),
      .rsp_ready      (rsp_ready),
      .status         (buf_status),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end),
      .rsp_stopped    (rsp_stopped)
   );

   `BED_ASSERT_NEXT(a_halt_sticks, clock, reset, dec_status.halted, dec_status.halted)
   `BED_ASSERT_SAME(a_stop_is_final, clock, reset, rsp_valid && rsp_stopped, rsp_run_last)
   `BED_ASSERT_SAME(a_last_gives_result, clock, reset,
      advance && in_last_ff && !dec_status.halted, list.count != '0)
   `BED_ASSERT_SAME(a_load_when_drained, clock, reset,
      advance && buf_status.busy, rsp_ready && rsp_run_last)

endmodule
